// ===== rtl/core/radix_string_converter_assert.svh =====
// ----------------------------------------------------------------------------
// radix string converter assertion macros
// shared concurrent assertion forms, sampled on clk and masked during rst
// ----------------------------------------------------------------------------
`ifndef RADIX_STRING_CONVERTER_ASSERT_SVH
`define RADIX_STRING_CONVERTER_ASSERT_SVH

// same-cycle implication
`define RSC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define RSC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/rsc_pkg.sv =====
// ----------------------------------------------------------------------------
// rsc_pkg
// payload types and fixed constants of the radix string converter
// ----------------------------------------------------------------------------
package rsc_pkg;

  localparam int VAL_W  = 32;
  localparam int CHAR_W = 8;
  localparam int LEN_W  = 8;
  // length compares need room for a depth of 256
  localparam int LEN_CMP_W = 9;

  // divider: quotient bits resolved per cycle
  localparam int DIV_BITS   = 4;
  localparam int DIV_CYCLES = VAL_W / DIV_BITS;
  localparam int DIV_CNT_W  = $clog2(DIV_CYCLES);

  localparam logic [CHAR_W-1:0] CH_MINUS   = 8'd45;
  localparam logic [CHAR_W-1:0] CH_PLUS    = 8'd43;
  localparam logic [CHAR_W-1:0] CH_LOWEST  = 8'd32;
  localparam logic [CHAR_W-1:0] CH_HIGHEST = 8'd126;

  localparam logic FUNC_LOAD    = 1'b0;
  localparam logic FUNC_CONVERT = 1'b1;

  typedef struct packed {
    logic              func;
    logic [6:0]        entry_index;
    logic [7:0]        entry_char;
    logic signed [31:0] value;
  } req_t;

  typedef struct packed {
    logic [7:0] char_code;
    logic       last;
    logic       base_invalid;
  } rsp_t;

  typedef struct packed {
    logic [VAL_W-1:0]  quotient;
    logic [LEN_W-1:0]  remainder;
  } div_result_t;

endpackage

// ===== rtl/core/rsc_divider.sv =====
// ----------------------------------------------------------------------------
// rsc_divider
// iterative 32 by 8 bit unsigned divider, restoring, DIV_BITS quotient bits per cycle
// ----------------------------------------------------------------------------
module rsc_divider (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [rsc_pkg::VAL_W-1:0]  dividend,
  input  logic [rsc_pkg::LEN_W-1:0]  divisor,
  output logic                       done,
  output rsc_pkg::div_result_t       result
);

  logic                          busy;
  logic [rsc_pkg::DIV_CNT_W-1:0] step;
  logic [rsc_pkg::VAL_W-1:0]     acc;
  logic [rsc_pkg::LEN_W-1:0]     rem;

  logic [rsc_pkg::VAL_W-1:0]     acc_next;
  logic [rsc_pkg::LEN_W-1:0]     rem_next;
  logic [rsc_pkg::LEN_W:0]       trial;

  // shift-subtract steps, quotient bits enter acc from the bottom
  always_comb begin
    acc_next = acc;
    rem_next = rem;
    trial    = '0;
    for (int k = 0; k < rsc_pkg::DIV_BITS; k++) begin
      trial    = {rem_next, acc_next[rsc_pkg::VAL_W-1]};
      acc_next = {acc_next[rsc_pkg::VAL_W-2:0], 1'b0};
      if (trial >= {1'b0, divisor}) begin
        rem_next    = rsc_pkg::LEN_W'(trial - {1'b0, divisor});
        acc_next[0] = 1'b1;
      end else begin
        rem_next = trial[rsc_pkg::LEN_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
      step <= '0;
    end else if (busy) begin
      step <= step + 1'b1;
      if (step == rsc_pkg::DIV_CNT_W'(rsc_pkg::DIV_CYCLES - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end else begin
      done <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc <= dividend;
      rem <= '0;
    end else if (busy) begin
      acc <= acc_next;
      rem <= rem_next;
    end
  end

  assign result.quotient  = acc;
  assign result.remainder = rem;

endmodule

// ===== rtl/core/radix_string_converter.sv =====
// ----------------------------------------------------------------------------
// radix_string_converter
// signed 32-bit integer to character string in a loadable digit alphabet
// ----------------------------------------------------------------------------
// usage
//   cfg_wr_en/cfg_wr_data set the alphabet length (the radix); write it only
//   while the block is idle. requests arrive on req_valid/req_ready/req_data.
//   a load request writes one alphabet entry and gives nothing.
//   a convert request checks the alphabet (a read and a test state per entry,
//   one shared range, sign-character and duplicate test against a bitmap of
//   codes seen), then divides the magnitude by the radix in the shared
//   divider, with a start and a wait state of hand-over per digit, then
//   streams '-' if negative and the digits, most significant first, on
//   rsp_valid/rsp_ready/rsp_data, each through a digit buffer read, an
//   alphabet read and an output state.
//   a failed check gives one result with base_invalid and last set.
//   req_ready is low until the last character is in the output register.
//   a stalled receiver holds the output register and the sequencer waits.
//   reset clears the length and the control state; alphabet contents stay
//   undefined until loaded.
// ----------------------------------------------------------------------------
module radix_string_converter #(
  parameter int ALPHABET_DEPTH = 128,
  parameter int DIGIT_SLOTS    = 32
) (
  input  logic                       clk,
  input  logic                       rst,
  // configuration
  input  logic                       cfg_wr_en,
  input  logic [rsc_pkg::LEN_W-1:0]  cfg_wr_data,
  // request channel
  input  logic                       req_valid,
  output logic                       req_ready,
  input  rsc_pkg::req_t              req_data,
  // result channel
  output logic                       rsp_valid,
  input  logic                       rsp_ready,
  output rsc_pkg::rsp_t              rsp_data
);

  // alphabet address, alphabet counter, digit buffer address and digit count
  localparam int AW = $clog2(ALPHABET_DEPTH);
  localparam int LW = $clog2(ALPHABET_DEPTH + 1);
  localparam int BW = $clog2(DIGIT_SLOTS);
  localparam int CW = $clog2(DIGIT_SLOTS + 1);

  localparam logic [3:0] ST_IDLE       = 4'd0;
  localparam logic [3:0] ST_CHK_RD     = 4'd1;
  localparam logic [3:0] ST_CHK_TEST   = 4'd2;
  localparam logic [3:0] ST_BAD        = 4'd3;
  localparam logic [3:0] ST_DIV_GO     = 4'd4;
  localparam logic [3:0] ST_DIV_WAIT   = 4'd5;
  localparam logic [3:0] ST_SIGN       = 4'd6;
  localparam logic [3:0] ST_EMIT_RD    = 4'd7;
  localparam logic [3:0] ST_EMIT_ALPHA = 4'd8;
  localparam logic [3:0] ST_EMIT_OUT   = 4'd9;

  logic [3:0]                   state;
  logic [rsc_pkg::LEN_W-1:0]    alphabet_length;
  logic                         negative;
  logic [rsc_pkg::VAL_W-1:0]    magnitude;
  logic [LW-1:0]                chk_idx;
  logic [127:0]                 seen;
  logic [CW-1:0]                cnt;
  logic [rsc_pkg::CHAR_W-1:0]   alpha_q;
  logic [AW-1:0]                dbuf_q;

  // alphabet store and digit buffer
  logic [rsc_pkg::CHAR_W-1:0]   alphabet [ALPHABET_DEPTH];
  logic [AW-1:0]                dbuf [DIGIT_SLOTS];

  logic                         req_fire;
  logic                         rsp_free;
  logic                         rsp_load;
  logic                         load_ok;
  logic                         len_bad;
  logic [LW-1:0]                chk_idx_next;
  logic                         char_bad;
  logic [CW-1:0]                cnt_next;
  logic [CW-1:0]                cnt_dec;
  logic [AW-1:0]                alpha_raddr;
  logic                         alpha_rd;
  logic [rsc_pkg::VAL_W-1:0]    raw;

  // shared divider interface
  logic                         div_start;
  logic                         div_done;
  rsc_pkg::div_result_t         div_res;

  assign req_ready = (state == ST_IDLE);
  assign req_fire  = req_valid && req_ready;
  // output register may take a new character
  assign rsp_free  = !rsp_valid || rsp_ready;
  // the sequencer places a character in the output register
  assign rsp_load  = rsp_free && ((state == ST_BAD) || (state == ST_EMIT_OUT) ||
                                  (state == ST_SIGN && negative));

  assign load_ok = (32'(req_data.entry_index) < ALPHABET_DEPTH);
  assign len_bad = (alphabet_length < rsc_pkg::LEN_W'(2)) ||
                   (rsc_pkg::LEN_CMP_W'(alphabet_length) >
                    rsc_pkg::LEN_CMP_W'(ALPHABET_DEPTH));

  assign chk_idx_next = chk_idx + 1'b1;
  // range, sign characters and repeats, checked entry by entry
  assign char_bad = (alpha_q == rsc_pkg::CH_MINUS) || (alpha_q == rsc_pkg::CH_PLUS) ||
                    (alpha_q < rsc_pkg::CH_LOWEST) || (alpha_q > rsc_pkg::CH_HIGHEST) ||
                    seen[alpha_q[6:0]];

  assign cnt_next = cnt + 1'b1;
  assign cnt_dec  = cnt - 1'b1;

  assign raw = $unsigned(req_data.value);

  // one read port: validation walks the entries, emission looks up digits
  assign alpha_raddr = (state == ST_CHK_RD) ? chk_idx[AW-1:0] : dbuf_q;
  assign alpha_rd    = (state == ST_CHK_RD) || (state == ST_EMIT_ALPHA);

  assign div_start = (state == ST_DIV_GO);

  rsc_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (magnitude),
    .divisor  (alphabet_length),
    .done     (div_done),
    .result   (div_res)
  );

  // alphabet memory
  always_ff @(posedge clk) begin
    if (req_fire && req_data.func == rsc_pkg::FUNC_LOAD && load_ok) begin
      alphabet[AW'(req_data.entry_index)] <= req_data.entry_char;
    end
    if (alpha_rd) begin
      alpha_q <= alphabet[alpha_raddr];
    end
  end

  // digit buffer, least significant digit first
  always_ff @(posedge clk) begin
    if (state == ST_DIV_WAIT && div_done) begin
      dbuf[BW'(cnt)] <= div_res.remainder[AW-1:0];
    end
    if (state == ST_EMIT_RD) begin
      dbuf_q <= dbuf[BW'(cnt_dec)];
    end
  end

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      alphabet_length <= '0;
    end else if (cfg_wr_en) begin
      alphabet_length <= cfg_wr_data;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      rsp_valid <= 1'b0;
      magnitude <= '0;
      negative  <= 1'b0;
      chk_idx   <= '0;
      cnt       <= '0;
      seen      <= '0;
    end else begin
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (req_fire && req_data.func == rsc_pkg::FUNC_CONVERT) begin
            negative  <= raw[rsc_pkg::VAL_W-1];
            magnitude <= raw[rsc_pkg::VAL_W-1] ? (rsc_pkg::VAL_W'(0) - raw) : raw;
            cnt       <= '0;
            chk_idx   <= '0;
            seen      <= '0;
            state     <= len_bad ? ST_BAD : ST_CHK_RD;
          end
        end
        ST_CHK_RD: begin
          state <= ST_CHK_TEST;
        end
        ST_CHK_TEST: begin
          if (char_bad) begin
            state <= ST_BAD;
          end else begin
            seen[alpha_q[6:0]] <= 1'b1;
            chk_idx            <= chk_idx_next;
            if (rsc_pkg::LEN_CMP_W'(chk_idx_next) ==
                rsc_pkg::LEN_CMP_W'(alphabet_length)) begin
              state <= ST_DIV_GO;
            end else begin
              state <= ST_CHK_RD;
            end
          end
        end
        ST_BAD: begin
          if (rsp_free) begin
            rsp_data.char_code     <= '0;
            rsp_data.last          <= 1'b1;
            rsp_data.base_invalid  <= 1'b1;
            state                  <= ST_IDLE;
          end
        end
        ST_DIV_GO: begin
          state <= ST_DIV_WAIT;
        end
        ST_DIV_WAIT: begin
          if (div_done) begin
            magnitude <= div_res.quotient;
            cnt       <= cnt_next;
            if (div_res.quotient != '0 && 32'(cnt_next) < DIGIT_SLOTS) begin
              state <= ST_DIV_GO;
            end else begin
              state <= ST_SIGN;
            end
          end
        end
        ST_SIGN: begin
          if (!negative) begin
            state <= ST_EMIT_RD;
          end else if (rsp_free) begin
            rsp_data.char_code     <= rsc_pkg::CH_MINUS;
            rsp_data.last          <= 1'b0;
            rsp_data.base_invalid  <= 1'b0;
            state                  <= ST_EMIT_RD;
          end
        end
        ST_EMIT_RD: begin
          cnt   <= cnt_dec;
          state <= ST_EMIT_ALPHA;
        end
        ST_EMIT_ALPHA: begin
          state <= ST_EMIT_OUT;
        end
        ST_EMIT_OUT: begin
          if (rsp_free) begin
            rsp_data.char_code     <= alpha_q;
            rsp_data.last          <= (cnt == '0);
            rsp_data.base_invalid  <= 1'b0;
            state                  <= (cnt == '0) ? ST_IDLE : ST_EMIT_RD;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

`include "radix_string_converter_assert.svh"

  // a flagged result is always alone and carries no character
  `RSC_ASSERT_NOW(a_bad_alone, rsp_valid && rsp_data.base_invalid, rsp_data.last && rsp_data.char_code == '0, "invalid result not a lone empty last")
  // the divider only finishes while the sequencer waits on it
  `RSC_ASSERT_NOW(a_div_owned, div_done, state == ST_DIV_WAIT, "divider done outside wait state")
  // the digit count stays within the buffer
  `RSC_ASSERT_NOW(a_cnt_range, 1'b1, 32'(cnt) <= DIGIT_SLOTS, "digit count beyond buffer")
  // a convert request always starts work
  `RSC_ASSERT_NEXT(a_conv_busy, req_fire && req_data.func == rsc_pkg::FUNC_CONVERT, state != ST_IDLE, "convert request left block idle")

endmodule
